// ===== rtl/core/point_segment_distance_3d_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the distance block checkers.
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_3D_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_3D_MACROS_SVH

// checked only while out of reset
`define PSD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PSD_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Constants shared by the point to segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int NUM_AXES     = 3;
    localparam int DIST_WIDTH   = 33;
    localparam int M_DATA_WIDTH = ((DIST_WIDTH + 7) / 8) * 8;
    localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

endpackage

// ===== rtl/core/psd_front.sv =====
// ----------------------------------------------------------------------------
// psd_front
// Differences, products, dot and length sums, and divider set-up.
// ----------------------------------------------------------------------------
module psd_front #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 24
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic [9*COORD_WIDTH-1:0]                     in_data,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output logic [2*COORD_WIDTH+3:0]                     out_r,
    output logic [2*COORD_WIDTH+3:0]                     out_len2,
    output logic [FRACTION_BITS:0]                       out_t,
    output logic                                         out_run,
    output logic [6*(COORD_WIDTH+1):0]                   out_side
);
    import psd_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int LW = 2 * COORD_WIDTH + 4;

    logic [4:1] v_reg;
    logic [5:1] adv;

    logic signed [DW-1:0] ab1_reg [NUM_AXES];
    logic signed [DW-1:0] ap1_reg [NUM_AXES];
    logic signed [DW-1:0] ab2_reg [NUM_AXES];
    logic signed [DW-1:0] ap2_reg [NUM_AXES];
    logic signed [PW-1:0] sq2_reg [NUM_AXES];
    logic signed [PW-1:0] dp2_reg [NUM_AXES];
    logic signed [DW-1:0] ab3_reg [NUM_AXES];
    logic signed [DW-1:0] ap3_reg [NUM_AXES];
    logic [LW-1:0]        len3_reg;
    logic [LW-1:0]        dot3_reg;

    logic [LW-1:0]        r4_reg, len4_reg;
    logic [FRACTION_BITS:0] t4_reg;
    logic                 run4_reg;
    logic [6*DW:0]        side4_reg;

    logic [LW-1:0] len_sum, dot_sum;
    logic          degen, dot_pos, dot_ge;

    assign adv[5] = out_ready;
    assign adv[4] = !v_reg[4] || adv[5];
    assign adv[3] = !v_reg[3] || adv[4];
    assign adv[2] = !v_reg[2] || adv[3];
    assign adv[1] = !v_reg[1] || adv[2];
    assign in_ready = adv[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[1]) v_reg[1] <= in_valid;
            if (adv[2]) v_reg[2] <= v_reg[1];
            if (adv[3]) v_reg[3] <= v_reg[2];
            if (adv[4]) v_reg[4] <= v_reg[3];
        end
    end

    always_comb begin
        len_sum = '0;
        dot_sum = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            len_sum = len_sum + LW'($unsigned(sq2_reg[i]));
            dot_sum = dot_sum + {{(LW-PW){dp2_reg[i][PW-1]}}, dp2_reg[i]};
        end
    end

    assign degen   = (len3_reg == '0);
    assign dot_pos = !dot3_reg[LW-1] && (dot3_reg != '0);
    assign dot_ge  = (dot3_reg >= len3_reg);

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                ab1_reg[i] <= $signed({in_data[(6+i)*COORD_WIDTH+COORD_WIDTH-1],
                                       in_data[(6+i)*COORD_WIDTH +: COORD_WIDTH]})
                            - $signed({in_data[(3+i)*COORD_WIDTH+COORD_WIDTH-1],
                                       in_data[(3+i)*COORD_WIDTH +: COORD_WIDTH]});
                ap1_reg[i] <= $signed({in_data[i*COORD_WIDTH+COORD_WIDTH-1],
                                       in_data[i*COORD_WIDTH +: COORD_WIDTH]})
                            - $signed({in_data[(3+i)*COORD_WIDTH+COORD_WIDTH-1],
                                       in_data[(3+i)*COORD_WIDTH +: COORD_WIDTH]});
            end
        end
        if (adv[2]) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                sq2_reg[i] <= ab1_reg[i] * ab1_reg[i];
                dp2_reg[i] <= ab1_reg[i] * ap1_reg[i];
                ab2_reg[i] <= ab1_reg[i];
                ap2_reg[i] <= ap1_reg[i];
            end
        end
        if (adv[3]) begin
            len3_reg <= len_sum;
            dot3_reg <= dot_sum;
            for (int i = 0; i < NUM_AXES; i++) begin
                ab3_reg[i] <= ab2_reg[i];
                ap3_reg[i] <= ap2_reg[i];
            end
        end
        if (adv[4]) begin
            r4_reg   <= dot3_reg;
            len4_reg <= len3_reg;
            run4_reg <= !degen && dot_pos && !dot_ge;
            // projection at or past the end clamps to exactly 1.0
            t4_reg   <= (!degen && dot_pos && dot_ge) ?
                        ((FRACTION_BITS+1)'(1) << FRACTION_BITS) : '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                side4_reg[i*DW +: DW]     <= ab3_reg[i];
                side4_reg[(3+i)*DW +: DW] <= ap3_reg[i];
            end
            side4_reg[6*DW] <= degen;
        end
    end

    assign out_valid = v_reg[4];
    assign out_r     = r4_reg;
    assign out_len2  = len4_reg;
    assign out_t     = t4_reg;
    assign out_run   = run4_reg;
    assign out_side  = side4_reg;

endmodule

// ===== rtl/core/psd_div_cell.sv =====
// ----------------------------------------------------------------------------
// psd_div_cell
// One restoring divide step for the projection fraction.
// ----------------------------------------------------------------------------
module psd_div_cell #(
    parameter int LW = 68,
    parameter int TW = 25,
    parameter int SW = 199
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [LW-1:0] in_r,
    input  logic [LW-1:0] in_len2,
    input  logic [TW-1:0] in_t,
    input  logic          in_run,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [LW-1:0] out_r,
    output logic [LW-1:0] out_len2,
    output logic [TW-1:0] out_t,
    output logic          out_run,
    output logic [SW-1:0] out_side
);
    logic          v_reg;
    logic [LW-1:0] r_reg, len2_reg, r_next;
    logic [TW-1:0] t_reg, t_next;
    logic          run_reg;
    logic [SW-1:0] side_reg;
    logic [LW+1:0] diff;
    logic          ge;

    assign in_ready = !v_reg || out_ready;

    assign diff   = {1'b0, in_r, 1'b0} - {2'b00, in_len2};
    assign ge     = !diff[LW+1];
    assign r_next = !in_run ? in_r : (ge ? diff[LW-1:0] : {in_r[LW-2:0], 1'b0});
    assign t_next = in_run ? {in_t[TW-2:0], ge} : in_t;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            r_reg    <= r_next;
            len2_reg <= in_len2;
            t_reg    <= t_next;
            run_reg  <= in_run;
            side_reg <= in_side;
        end
    end

    assign out_valid = v_reg;
    assign out_r     = r_reg;
    assign out_len2  = len2_reg;
    assign out_t     = t_reg;
    assign out_run   = run_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/core/psd_back.sv =====
// ----------------------------------------------------------------------------
// psd_back
// Closest point offset, residual vector and squared distance.
// ----------------------------------------------------------------------------
module psd_back #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [FRACTION_BITS:0]         in_t,
    input  logic [6*(COORD_WIDTH+1):0]     in_side,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2*COORD_WIDTH+3:0]       out_dist2,
    output logic                           out_degen
);
    import psd_pkg::*;

    localparam int DW  = COORD_WIDTH + 1;
    localparam int OW  = COORD_WIDTH + 2;
    localparam int RW  = COORD_WIDTH + 3;
    localparam int PRW = FRACTION_BITS + 2 + DW;
    localparam int SQW = 2 * RW;
    localparam int LW  = 2 * COORD_WIDTH + 4;

    logic [4:1] v_reg;
    logic [5:1] adv;
    logic [4:1] dg_reg;

    logic signed [OW-1:0]  off1_reg [NUM_AXES];
    logic signed [DW-1:0]  ap1_reg  [NUM_AXES];
    logic signed [RW-1:0]  d2_reg   [NUM_AXES];
    logic [SQW-1:0]        sq3_reg  [NUM_AXES];
    logic [LW-1:0]         sum4_reg;

    logic signed [PRW-1:0] prod [NUM_AXES];
    logic [SQW-1:0]        sq_sum;

    assign adv[5] = out_ready;
    assign adv[4] = !v_reg[4] || adv[5];
    assign adv[3] = !v_reg[3] || adv[4];
    assign adv[2] = !v_reg[2] || adv[3];
    assign adv[1] = !v_reg[1] || adv[2];
    assign in_ready = adv[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[1]) v_reg[1] <= in_valid;
            if (adv[2]) v_reg[2] <= v_reg[1];
            if (adv[3]) v_reg[3] <= v_reg[2];
            if (adv[4]) v_reg[4] <= v_reg[3];
        end
    end

    // arithmetic shift floors towards minus infinity for a negative step
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            prod[i] = $signed({1'b0, in_t}) * $signed(in_side[i*DW +: DW]);
        end
        sq_sum = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            sq_sum = sq_sum + sq3_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                off1_reg[i] <= OW'(prod[i] >>> FRACTION_BITS);
                ap1_reg[i]  <= $signed(in_side[(3+i)*DW +: DW]);
            end
            dg_reg[1] <= in_side[6*DW];
        end
        if (adv[2]) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                d2_reg[i] <= {{(RW-DW){ap1_reg[i][DW-1]}}, ap1_reg[i]}
                           - {{(RW-OW){off1_reg[i][OW-1]}}, off1_reg[i]};
            end
            dg_reg[2] <= dg_reg[1];
        end
        if (adv[3]) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                sq3_reg[i] <= $unsigned(SQW'(d2_reg[i]) * SQW'(d2_reg[i]));
            end
            dg_reg[3] <= dg_reg[2];
        end
        if (adv[4]) begin
            sum4_reg  <= sq_sum[LW-1:0];
            dg_reg[4] <= dg_reg[3];
        end
    end

    assign out_valid = v_reg[4];
    assign out_dist2 = sum4_reg;
    assign out_degen = dg_reg[4];

endmodule

// ===== rtl/core/psd_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// psd_sqrt_cell
// One bit of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module psd_sqrt_cell #(
    parameter int RW  = 34,
    parameter int BIT = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [2*RW-1:0] in_rem,
    input  logic [RW-1:0]   in_root,
    input  logic            in_degen,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [2*RW-1:0] out_rem,
    output logic [RW-1:0]   out_root,
    output logic            out_degen
);
    localparam int XW = 2 * RW + 2;

    logic            v_reg;
    logic [2*RW-1:0] rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic            degen_reg;
    logic [XW-1:0]   trial;
    logic            ge;

    assign in_ready = !v_reg || out_ready;

    // rem holds n - root^2; setting this bit costs (2*root + 2^BIT) * 2^BIT
    assign trial     = (XW'(in_root) << (BIT + 1)) + (XW'(1) << (2 * BIT));
    assign ge        = {2'b00, in_rem} >= trial;
    assign rem_next  = ge ? (in_rem - trial[2*RW-1:0]) : in_rem;
    assign root_next = ge ? (in_root | (RW'(1) << BIT)) : in_root;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            rem_reg   <= rem_next;
            root_reg  <= root_next;
            degen_reg <= in_degen;
        end
    end

    assign out_valid = v_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_degen = degen_reg;

endmodule

// ===== rtl/core/point_segment_distance_3d.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance_3d
// Distance from a point to a segment in 3D, one query per clock while the result side keeps up.
// ----------------------------------------------------------------------------
// A new query is taken every clock and one result leaves every clock while
// the result side keeps up. The path runs through four set-up stages, one
// divider cell per fraction bit, four stages forming the squared distance,
// one square root cell per result bit (COORD_WIDTH + 2) and the output
// register. Each stage holds its beat when the next one is full, so bubbles
// close up and input is still accepted while a finished result waits.
// ----------------------------------------------------------------------------
module point_segment_distance_3d #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // point_x, point_y, point_z, start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // distance
    output logic [psd_pkg::M_DATA_WIDTH-1:0]     m_tdata,
    // degenerate
    output logic                                 m_tuser
);
    import psd_pkg::*;

    localparam int LW = 2 * COORD_WIDTH + 4;
    localparam int TW = FRACTION_BITS + 1;
    localparam int SW = 6 * (COORD_WIDTH + 1) + 1;
    localparam int RW = COORD_WIDTH + 2;

    // divider chain
    logic          dv_valid [FRACTION_BITS+1];
    logic          dv_ready [FRACTION_BITS+1];
    logic [LW-1:0] dv_r     [FRACTION_BITS+1];
    logic [LW-1:0] dv_len2  [FRACTION_BITS+1];
    logic [TW-1:0] dv_t     [FRACTION_BITS+1];
    logic          dv_run   [FRACTION_BITS+1];
    logic [SW-1:0] dv_side  [FRACTION_BITS+1];

    // square root chain
    logic          sq_valid [RW+1];
    logic          sq_ready [RW+1];
    logic [LW-1:0] sq_rem   [RW+1];
    logic [RW-1:0] sq_root  [RW+1];
    logic          sq_degen [RW+1];

    logic                  m_tvalid_reg;
    logic [DIST_WIDTH-1:0] dist_reg, dist_next;
    logic                  degen_reg;

    psd_front #(
        .COORD_WIDTH  (COORD_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata[9*COORD_WIDTH-1:0]),
        .out_valid(dv_valid[0]),
        .out_ready(dv_ready[0]),
        .out_r    (dv_r[0]),
        .out_len2 (dv_len2[0]),
        .out_t    (dv_t[0]),
        .out_run  (dv_run[0]),
        .out_side (dv_side[0])
    );

    for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_div
        psd_div_cell #(
            .LW(LW),
            .TW(TW),
            .SW(SW)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (dv_valid[k]),
            .in_ready (dv_ready[k]),
            .in_r     (dv_r[k]),
            .in_len2  (dv_len2[k]),
            .in_t     (dv_t[k]),
            .in_run   (dv_run[k]),
            .in_side  (dv_side[k]),
            .out_valid(dv_valid[k+1]),
            .out_ready(dv_ready[k+1]),
            .out_r    (dv_r[k+1]),
            .out_len2 (dv_len2[k+1]),
            .out_t    (dv_t[k+1]),
            .out_run  (dv_run[k+1]),
            .out_side (dv_side[k+1])
        );
    end

    psd_back #(
        .COORD_WIDTH  (COORD_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (dv_valid[FRACTION_BITS]),
        .in_ready (dv_ready[FRACTION_BITS]),
        .in_t     (dv_t[FRACTION_BITS]),
        .in_side  (dv_side[FRACTION_BITS]),
        .out_valid(sq_valid[0]),
        .out_ready(sq_ready[0]),
        .out_dist2(sq_rem[0]),
        .out_degen(sq_degen[0])
    );

    assign sq_root[0] = '0;

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        psd_sqrt_cell #(
            .RW (RW),
            .BIT(RW - 1 - k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (sq_valid[k]),
            .in_ready (sq_ready[k]),
            .in_rem   (sq_rem[k]),
            .in_root  (sq_root[k]),
            .in_degen (sq_degen[k]),
            .out_valid(sq_valid[k+1]),
            .out_ready(sq_ready[k+1]),
            .out_rem  (sq_rem[k+1]),
            .out_root (sq_root[k+1]),
            .out_degen(sq_degen[k+1])
        );
    end

    // saturate roots wider than the result field
    if (RW > DIST_WIDTH) begin : g_sat
        assign dist_next = (sq_root[RW][RW-1:DIST_WIDTH] != '0) ? DIST_MAX
                         : sq_root[RW][DIST_WIDTH-1:0];
    end else begin : g_ext
        assign dist_next = DIST_WIDTH'(sq_root[RW]);
    end

    assign sq_ready[RW] = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (sq_ready[RW]) begin
            m_tvalid_reg <= sq_valid[RW];
        end
    end

    always_ff @(posedge aclk) begin
        if (sq_ready[RW]) begin
            dist_reg  <= dist_next;
            degen_reg <= sq_degen[RW];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_WIDTH'(dist_reg);
    assign m_tuser  = degen_reg;

endmodule

// ===== rtl/core/psd_checker.sv =====
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks on the result stream of the distance block.
// ----------------------------------------------------------------------------
`include "point_segment_distance_3d_macros.svh"

module psd_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [((9*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [psd_pkg::M_DATA_WIDTH-1:0]    m_tdata,
    input logic                                m_tuser
);
    import psd_pkg::*;

    logic unused_in;
    assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata);

    `PSD_ASSERT(a_rst_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    `PSD_ASSERT_RST(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped while stalled")

    `PSD_ASSERT_RST(a_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    `PSD_ASSERT_RST(a_pad_zero, aclk, aresetn, m_tvalid |-> m_tdata[M_DATA_WIDTH-1:DIST_WIDTH] == '0, "padding bits set in result")

endmodule

bind point_segment_distance_3d psd_checker #(.COORD_WIDTH(COORD_WIDTH)) u_psd_checker (.*);
